// ===== src/gpbs_pkg.sv =====
// gpbs_pkg: shared types, codes and constants of the graphic lcd bus sequencer
// no dependencies; used by gpbs_ctrl, gpbs_out_reg and glcd_pixel_bus_sequencer
package gpbs_pkg;

  // default geometry of one display half and of the page count
  localparam int unsigned COLS_PER_CHIP_DEF = 64;
  localparam int unsigned PAGE_COUNT_DEF    = 8;

  // controller commands
  localparam logic [7:0] CMD_ON         = 8'h3F;
  localparam logic [7:0] CMD_COLUMN     = 8'h40;
  localparam logic [7:0] CMD_PAGE       = 8'hB8;
  localparam logic [7:0] CMD_START_LINE = 8'hC0;

  // chip select codes
  localparam logic [1:0] CS_LEFT  = 2'd0;
  localparam logic [1:0] CS_RIGHT = 2'd1;
  localparam logic [1:0] CS_BOTH  = 2'd2;

  // request codes of an input item
  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_PIXEL = 2'd2,
    REQ_SLOT  = 2'd3
  } req_e;

  // running sequence
  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_INIT  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_PIXEL = 2'd3
  } kind_e;

  // one bus operation
  typedef struct packed {
    logic [1:0] chip_select;
    logic       data_mode;
    logic       read_op;
    logic [7:0] bus_value;
    logic       last;
  } op_t;

endpackage

// ===== src/gpbs_ctrl.sv =====
// gpbs_ctrl: sequence state and per-slot bus operation generation
// depends on gpbs_pkg
module gpbs_ctrl #(
  parameter int unsigned COLS_PER_CHIP = gpbs_pkg::COLS_PER_CHIP_DEF,
  parameter int unsigned PAGE_COUNT    = gpbs_pkg::PAGE_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  gpbs_pkg::req_e  req_i,
  input  logic [7:0]      x_i,
  input  logic [7:0]      y_i,
  input  logic            color_i,
  input  logic [7:0]      read_data_i,
  output logic            op_valid_o,
  output gpbs_pkg::op_t   op_o
);

  localparam int unsigned RW  = $clog2(COLS_PER_CHIP + 2);
  localparam int unsigned PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned XM  = 2 * COLS_PER_CHIP;
  localparam int unsigned XQ_MAX = 255 / XM;
  localparam int unsigned XQW = (XQ_MAX > 0) ? $clog2(XQ_MAX + 1) : 1;
  localparam int unsigned YQ_MAX = 31 / PAGE_COUNT;
  localparam int unsigned YQW = (YQ_MAX > 0) ? $clog2(YQ_MAX + 1) : 1;
  // reciprocals scaled by 2^16, exact for the small dividends here
  localparam int unsigned X_RECIP = (65536 + XM - 1) / XM;
  localparam int unsigned Y_RECIP = (65536 + PAGE_COUNT - 1) / PAGE_COUNT;

  localparam logic [RW-1:0] R_LAST_CLR = RW'(COLS_PER_CHIP + 1);
  localparam logic [PW-1:0] PAGE_LAST  = PW'(PAGE_COUNT - 1);

  // set pixel steps
  localparam logic [RW-1:0] PX_COL_A   = RW'(0);
  localparam logic [RW-1:0] PX_PAGE_A  = RW'(1);
  localparam logic [RW-1:0] PX_RD_DUM  = RW'(2);
  localparam logic [RW-1:0] PX_RD_REAL = RW'(3);
  localparam logic [RW-1:0] PX_COL_B   = RW'(4);
  localparam logic [RW-1:0] PX_PAGE_B  = RW'(5);
  localparam logic [RW-1:0] PX_WRITE   = RW'(6);

  gpbs_pkg::kind_e kind_q, kind_d;
  logic [RW-1:0]   r_q, r_d;
  logic            chip_q, chip_d;
  logic [PW-1:0]   page_q, page_d;

  logic [7:0]      x_q, x_d;
  logic [XQW-1:0]  xq_q, xq_d;
  logic [4:0]      ypg_q, ypg_d;
  logic [YQW-1:0]  yq_q, yq_d;
  logic [2:0]      bit_q, bit_d;
  logic            color_q, color_d;
  logic [7:0]      cap_q, cap_d;

  logic [25:0]     x_prod, y_prod;
  logic [8:0]      col_mod;
  logic            px_chip;
  logic [8:0]      px_col;
  logic [4:0]      px_page;
  logic [7:0]      px_mask;
  logic [7:0]      px_data;
  logic [1:0]      px_cs;

  // quotients for the modulo reductions, taken at start
  assign x_prod = 26'(x_i) * 26'(X_RECIP);
  assign y_prod = 26'(y_i[7:3]) * 26'(Y_RECIP);

  // pixel address from the stored operands and quotients
  assign col_mod = 9'(x_q) - 9'(xq_q) * 9'(XM);
  assign px_chip = (col_mod >= 9'(COLS_PER_CHIP));
  assign px_col  = px_chip ? (col_mod - 9'(COLS_PER_CHIP)) : col_mod;
  assign px_page = ypg_q - 5'(yq_q) * 5'(PAGE_COUNT);
  assign px_cs   = px_chip ? gpbs_pkg::CS_RIGHT : gpbs_pkg::CS_LEFT;
  assign px_mask = 8'h01 << bit_q;
  assign px_data = color_q ? (cap_q | px_mask) : (cap_q & ~px_mask);

  always_comb begin
    kind_d     = kind_q;
    r_d        = r_q;
    chip_d     = chip_q;
    page_d     = page_q;
    x_d        = x_q;
    xq_d       = xq_q;
    ypg_d      = ypg_q;
    yq_d       = yq_q;
    bit_d      = bit_q;
    color_d    = color_q;
    cap_d      = cap_q;
    op_valid_o = 1'b0;
    op_o       = '0;
    if (fire_i) begin
      if (req_i != gpbs_pkg::REQ_SLOT) begin
        // start while busy is dropped
        if (kind_q == gpbs_pkg::KIND_IDLE) begin
          r_d    = '0;
          chip_d = 1'b0;
          page_d = '0;
          case (req_i)
            gpbs_pkg::REQ_INIT:  kind_d = gpbs_pkg::KIND_INIT;
            gpbs_pkg::REQ_CLEAR: kind_d = gpbs_pkg::KIND_CLEAR;
            gpbs_pkg::REQ_PIXEL: begin
              kind_d  = gpbs_pkg::KIND_PIXEL;
              x_d     = x_i;
              xq_d    = x_prod[16 +: XQW];
              ypg_d   = y_i[7:3];
              yq_d    = y_prod[16 +: YQW];
              bit_d   = y_i[2:0];
              color_d = color_i;
            end
            default: ;
          endcase
        end
      end else begin
        case (kind_q)
          gpbs_pkg::KIND_INIT: begin
            op_valid_o        = 1'b1;
            op_o.chip_select  = gpbs_pkg::CS_BOTH;
            if (r_q == '0) begin
              op_o.bus_value = gpbs_pkg::CMD_ON;
              r_d            = RW'(1);
            end else begin
              // hand over to the full clear
              op_o.bus_value = gpbs_pkg::CMD_START_LINE;
              kind_d         = gpbs_pkg::KIND_CLEAR;
              r_d            = '0;
              chip_d         = 1'b0;
              page_d         = '0;
            end
          end
          gpbs_pkg::KIND_CLEAR: begin
            op_valid_o       = 1'b1;
            op_o.chip_select = chip_q ? gpbs_pkg::CS_RIGHT : gpbs_pkg::CS_LEFT;
            if (r_q == '0) begin
              op_o.bus_value = gpbs_pkg::CMD_COLUMN;
            end else if (r_q == RW'(1)) begin
              op_o.bus_value = gpbs_pkg::CMD_PAGE | (8'(page_q) & 8'h07);
            end else begin
              op_o.data_mode = 1'b1;
            end
            op_o.last = chip_q && (page_q == PAGE_LAST) && (r_q == R_LAST_CLR);
            if (r_q == R_LAST_CLR) begin
              r_d = '0;
              if (chip_q) begin
                chip_d = 1'b0;
                page_d = page_q + PW'(1);
              end else begin
                chip_d = 1'b1;
              end
            end else begin
              r_d = r_q + RW'(1);
            end
            if (op_o.last) begin
              kind_d = gpbs_pkg::KIND_IDLE;
              r_d    = '0;
            end
          end
          gpbs_pkg::KIND_PIXEL: begin
            op_valid_o       = 1'b1;
            op_o.chip_select = px_cs;
            r_d              = r_q + RW'(1);
            case (r_q)
              PX_COL_A, PX_COL_B: begin
                op_o.bus_value = gpbs_pkg::CMD_COLUMN | {2'b00, px_col[5:0]};
                // the real read byte arrives with the second column slot
                if (r_q == PX_COL_B) cap_d = read_data_i;
              end
              PX_PAGE_A, PX_PAGE_B: begin
                op_o.bus_value = gpbs_pkg::CMD_PAGE | {5'b00000, px_page[2:0]};
              end
              PX_RD_DUM, PX_RD_REAL: begin
                op_o.data_mode = 1'b1;
                op_o.read_op   = 1'b1;
              end
              default: begin
                op_o.data_mode = 1'b1;
                op_o.bus_value = px_data;
                op_o.last      = 1'b1;
                kind_d         = gpbs_pkg::KIND_IDLE;
                r_d            = '0;
              end
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= gpbs_pkg::KIND_IDLE;
      r_q    <= '0;
      chip_q <= 1'b0;
      page_q <= '0;
    end else begin
      kind_q <= kind_d;
      r_q    <= r_d;
      chip_q <= chip_d;
      page_q <= page_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    xq_q    <= xq_d;
    ypg_q   <= ypg_d;
    yq_q    <= yq_d;
    bit_q   <= bit_d;
    color_q <= color_d;
    cap_q   <= cap_d;
  end

  a_px_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == gpbs_pkg::KIND_PIXEL |-> r_q <= PX_WRITE)
    else $error("pixel step out of range");

  a_clr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == gpbs_pkg::KIND_CLEAR |-> (r_q <= R_LAST_CLR) && (page_q <= PAGE_LAST))
    else $error("clear position out of range");

  a_init_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == gpbs_pkg::KIND_INIT |-> r_q <= RW'(1))
    else $error("init step out of range");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_o && op_o.last |=> kind_q == gpbs_pkg::KIND_IDLE && r_q == '0)
    else $error("sequence not idle after last operation");

endmodule

// ===== src/gpbs_out_reg.sv =====
// gpbs_out_reg: result register between the sequencer and the output channel
// depends on gpbs_pkg
module gpbs_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic          op_valid_i,
  input  gpbs_pkg::op_t op_i,
  output logic          can_take_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gpbs_pkg::op_t op_o
);

  logic          valid_q, valid_d;
  gpbs_pkg::op_t op_q;

  // a held result that is taken this cycle frees the slot
  assign can_take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = op_valid_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && op_valid_i) begin
      op_q <= op_i;
    end
  end

  assign out_valid_o = valid_q;
  assign op_o        = op_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(op_q))
    else $error("held result lost");

  a_take_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> can_take_o)
    else $error("item taken without room");

  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && op_valid_i |=> valid_q)
    else $error("result dropped");

endmodule

// ===== src/glcd_pixel_bus_sequencer.sv =====
// glcd_pixel_bus_sequencer: top level of the dual-chip 128x64 lcd bus sequencer
// depends on gpbs_pkg, gpbs_ctrl and gpbs_out_reg
// a bus slot item's operation is held in the result register before it is shown
// throughput: one item per cycle while the output is not stalled, set by the single result register
// start items give no result; a start while a sequence runs is dropped
// reset: async active low, sequence goes idle, result register empty
module glcd_pixel_bus_sequencer #(
  parameter int unsigned COLS_PER_CHIP = gpbs_pkg::COLS_PER_CHIP_DEF,
  parameter int unsigned PAGE_COUNT    = gpbs_pkg::PAGE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic       color_i,
  input  logic [7:0] read_data_i,
  // bus operation channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] chip_select_o,
  output logic       data_mode_o,
  output logic       read_op_o,
  output logic [7:0] bus_value_o,
  output logic       last_o
);

  logic          fire;
  logic          can_take;
  logic          op_valid;
  gpbs_pkg::op_t op_next;
  gpbs_pkg::op_t op_out;

  // an item is taken whenever the result register has room or drains now
  assign in_ready_o = can_take;
  assign fire       = in_valid_i && can_take;

  // sequence state: kind, step counter, clear position, pixel operands
  gpbs_ctrl #(
    .COLS_PER_CHIP (COLS_PER_CHIP),
    .PAGE_COUNT    (PAGE_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_i       (gpbs_pkg::req_e'(req_type_i)),
    .x_i         (x_i),
    .y_i         (y_i),
    .color_i     (color_i),
    .read_data_i (read_data_i),
    .op_valid_o  (op_valid),
    .op_o        (op_next)
  );

  // result register decouples the downstream stall from intake
  gpbs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (fire),
    .op_valid_i  (op_valid),
    .op_i        (op_next),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .op_o        (op_out)
  );

  assign chip_select_o = op_out.chip_select;
  assign data_mode_o   = op_out.data_mode;
  assign read_op_o     = op_out.read_op;
  assign bus_value_o   = op_out.bus_value;
  assign last_o        = op_out.last;

  // a held result never changes until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bus_value_o)
      && $stable(chip_select_o) && $stable(last_o))
    else $error("output changed while stalled");

  // a read access never drives data
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_op_o |-> data_mode_o && bus_value_o == 8'h00)
    else $error("read access with data");

  // both chips are only selected for the init commands
  a_both_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chip_select_o == gpbs_pkg::CS_BOTH |->
      !data_mode_o && !last_o
      && (bus_value_o == gpbs_pkg::CMD_ON || bus_value_o == gpbs_pkg::CMD_START_LINE))
    else $error("bad broadcast operation");

endmodule
